### rtl/core/i2cdts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cdts_pkg
// types, codes and helpers for the i2c dynamic-mode transfer sequencer
// ----------------------------------------------------------------------------
package i2cdts_pkg;

  // longest message the buffer holds
  localparam int MAX_MSG_LEN = 255;

  // dynamic-mode tx fifo word flags
  localparam logic [9:0] WORD_START = 10'h100;
  localparam logic [9:0] WORD_STOP  = 10'h200;

  localparam logic [7:0] BLOCK_MAX_RESET = 8'd32;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_READY   = 2'd1,
    CMD_RECV    = 2'd2,
    CMD_BUS_ERR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_DONE  = 3'd0,
    PH_START = 3'd1,
    PH_WRITE = 3'd2,
    PH_READ  = 3'd3,
    PH_ERROR = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] msg_addr;
    logic       msg_read;
    logic       msg_recv_len;
    logic       msg_nostart;
    logic [7:0] msg_len;
    logic       msg_last;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       word_valid;
    logic [9:0] fifo_word;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic [2:0] phase;
    logic       need_next;
    logic       block_error;
  } out_word_t;

  // limit a length to what the message buffer holds
  function automatic logic [7:0] clamp_len(input logic [8:0] v);
    logic [7:0] r;
    if (v > 9'(MAX_MSG_LEN)) begin
      r = 8'(MAX_MSG_LEN);
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/i2c_dynamic_transfer_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_dynamic_transfer_sequencer_unit
// turns i2c message descriptors and bytes into dynamic-mode tx fifo words
// ----------------------------------------------------------------------------
//
//  channel  | signals                       | direction | word
//  ---------+-------------------------------+-----------+-------------------
//  in       | in_valid, in_stall, in_data   | sink      | i2cdts_pkg::in_word_t
//  out      | out_valid, out_stall, out_data| source    | i2cdts_pkg::out_word_t
//  cfg      | cfg_valid, cfg_ready, cfg_data| sink      | block_max, 8 bit
//
//  one word in per cycle while in_stall is low; each result is registered in the output register
//  the event decode and state update sit between in_data and the output register
//  a two-entry output buffer (output register plus skid register) keeps input
//  flowing while out_stall is high until the skid register fills; in_stall rises only once both hold data
//  synchronous reset clears the state, block_max returns to 32, no words pending
//
module i2c_dynamic_transfer_sequencer_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cdts_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cdts_pkg::out_word_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);

  // sequencer state
  i2cdts_pkg::phase_t phase, phase_next;
  logic [7:0] position, position_next;
  logic [7:0] length, length_next;
  logic       is_read, is_read_next;
  logic       is_block, is_block_next;
  logic       is_last, is_last_next;
  logic [7:0] first_byte, first_byte_next;
  logic       awaiting, awaiting_next;
  logic [7:0] block_max;

  // output buffer
  logic                  skid_valid;
  i2cdts_pkg::out_word_t skid_data;
  i2cdts_pkg::out_word_t result;

  logic in_acc;
  logic out_free;

  // event decode
  logic       start_xfer;   // descriptor opens a new transfer
  logic       cont_load;    // descriptor for the awaited next message
  logic       rd_req;       // ready in start phase of a read
  logic       wr_enter;     // ready in start phase of a write
  logic       wr_phase;     // write phase, counting the one just entered
  logic       wr_last;      // last byte of the last write message
  logic       wr_byte;      // ordinary write byte
  logic       rx_take;      // received byte stored
  logic       chk;          // message end reached
  logic       chk_blk;      // message end of a block read
  logic       bad_len;      // block length byte zero or above block_max
  logic [7:0] pos_mid;
  logic [7:0] fb_mid;
  logic [7:0] load_len;
  logic [7:0] blk_req_len;
  logic [9:0] addr_word;

  assign in_stall  = skid_valid;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & ~skid_valid;
  assign out_free  = ~out_valid | ~out_stall;

  assign load_len    = i2cdts_pkg::clamp_len({1'b0, in_data.msg_len});
  assign blk_req_len = i2cdts_pkg::clamp_len({1'b0, block_max} + 9'd2);
  assign addr_word   = {2'b00, in_data.msg_addr, in_data.msg_read} | i2cdts_pkg::WORD_START;

  always_comb begin
    start_xfer = 1'b0;
    cont_load  = 1'b0;
    rd_req     = 1'b0;
    wr_enter   = 1'b0;
    wr_phase   = 1'b0;
    wr_last    = 1'b0;
    wr_byte    = 1'b0;
    rx_take    = 1'b0;
    chk        = 1'b0;
    case (in_data.command)
      i2cdts_pkg::CMD_LOAD: begin
        start_xfer = (phase == i2cdts_pkg::PH_DONE) || (phase == i2cdts_pkg::PH_ERROR);
        cont_load  = ~start_xfer & awaiting;
      end
      i2cdts_pkg::CMD_READY: begin
        if (!awaiting) begin
          rd_req   = (phase == i2cdts_pkg::PH_START) & is_read;
          wr_enter = (phase == i2cdts_pkg::PH_START) & ~is_read;
          wr_phase = (phase == i2cdts_pkg::PH_WRITE) | wr_enter;
          wr_last  = wr_phase & (length != 8'd0) & (position == length - 8'd1) & is_last;
          wr_byte  = wr_phase & ~wr_last & (position < length);
          // message end check when nothing was sent
          chk      = ~rd_req & ~wr_last & ~wr_byte &
                     (wr_phase | (phase == i2cdts_pkg::PH_READ)) & (position >= length);
        end
      end
      i2cdts_pkg::CMD_RECV: begin
        if (!awaiting && phase == i2cdts_pkg::PH_READ) begin
          rx_take = position < length;
          chk     = (rx_take ? position + 8'd1 : position) >= length;
        end
      end
      default: ;
    endcase
    pos_mid = rx_take ? position + 8'd1 : position;
    fb_mid  = (rx_take && position == 8'd0) ? in_data.data_byte : first_byte;
    // only a read can be in read phase at its end check
    chk_blk = chk & is_block & (phase == i2cdts_pkg::PH_READ);
    bad_len = chk_blk & ((fb_mid == 8'd0) | (fb_mid > block_max));
  end

  // next state
  always_comb begin
    phase_next      = phase;
    position_next   = position;
    length_next     = length;
    is_read_next    = is_read;
    is_block_next   = is_block;
    is_last_next    = is_last;
    first_byte_next = first_byte;
    awaiting_next   = awaiting;

    if (in_data.command == i2cdts_pkg::CMD_BUS_ERR) begin
      phase_next    = i2cdts_pkg::PH_ERROR;
      awaiting_next = 1'b0;
    end

    if (start_xfer || cont_load) begin
      is_read_next  = in_data.msg_read;
      is_block_next = in_data.msg_recv_len;
      is_last_next  = in_data.msg_last;
      length_next   = load_len;
      position_next = 8'd0;
      awaiting_next = 1'b0;
      if (start_xfer || !in_data.msg_nostart) begin
        phase_next = i2cdts_pkg::PH_START;
      end
    end

    if (rd_req) begin
      phase_next = i2cdts_pkg::PH_READ;
      if (is_block) begin
        length_next = blk_req_len;
      end
    end

    if (wr_enter) begin
      phase_next = i2cdts_pkg::PH_WRITE;
    end

    if (wr_last) begin
      position_next = position + 8'd1;
      phase_next    = i2cdts_pkg::PH_DONE;
    end

    if (wr_byte) begin
      position_next = position + 8'd1;
    end

    if (rx_take) begin
      position_next   = pos_mid;
      first_byte_next = fb_mid;
    end

    // good message end: rewind, finish or wait for the next descriptor
    if (chk && !bad_len) begin
      if (chk_blk) begin
        length_next = i2cdts_pkg::clamp_len({1'b0, fb_mid} + 9'd1);
      end
      position_next = 8'd0;
      if (is_last) begin
        phase_next = i2cdts_pkg::PH_DONE;
      end else begin
        awaiting_next = 1'b1;
      end
    end
  end

  // result word
  always_comb begin
    result             = '0;
    result.phase       = phase_next;
    result.need_next   = awaiting_next;
    result.block_error = bad_len;
    if (start_xfer) begin
      result.word_valid = 1'b1;
      result.fifo_word  = addr_word;
      if (load_len == 8'd0 && in_data.msg_last) begin
        result.fifo_word = addr_word | i2cdts_pkg::WORD_STOP;
      end
    end else if (cont_load && !in_data.msg_nostart) begin
      result.word_valid = 1'b1;
      result.fifo_word  = addr_word;
    end else if (rd_req) begin
      result.word_valid = 1'b1;
      result.fifo_word  = {2'b00, length_next} | i2cdts_pkg::WORD_STOP;
    end else if (wr_last) begin
      result.word_valid = 1'b1;
      result.fifo_word  = {2'b00, in_data.data_byte} | i2cdts_pkg::WORD_STOP;
    end else if (wr_byte) begin
      result.word_valid = 1'b1;
      result.fifo_word  = {2'b00, in_data.data_byte};
    end
    if (rx_take) begin
      result.rx_valid = 1'b1;
      result.rx_byte  = in_data.data_byte;
      result.rx_index = position;
    end
  end

  // state registers, updated only on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2cdts_pkg::PH_DONE;
      position   <= 8'd0;
      length     <= 8'd0;
      is_read    <= 1'b0;
      is_block   <= 1'b0;
      is_last    <= 1'b0;
      first_byte <= 8'd0;
      awaiting   <= 1'b0;
    end else if (in_acc) begin
      phase      <= phase_next;
      position   <= position_next;
      length     <= length_next;
      is_read    <= is_read_next;
      is_block   <= is_block_next;
      is_last    <= is_last_next;
      first_byte <= first_byte_next;
      awaiting   <= awaiting_next;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_max <= i2cdts_pkg::BLOCK_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      block_max <= cfg_data;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid | in_acc;
      skid_valid <= 1'b0;
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (in_acc) begin
      skid_data <= result;
    end
  end

endmodule

### rtl/core/i2cdts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cdts_checker
// port-level checks of the i2c dynamic transfer sequencer
// ----------------------------------------------------------------------------
module i2cdts_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input i2cdts_pkg::in_word_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input i2cdts_pkg::out_word_t out_data,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [7:0]            cfg_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  // input only stalls when a result is already waiting
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // a bad block length keeps the read phase and pushes nothing
  a_blk_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.block_error |->
      out_data.phase == i2cdts_pkg::PH_READ && !out_data.word_valid && !out_data.need_next)
    else $error("block error outside read phase");

  // waiting for a descriptor only mid-transfer
  a_need_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.need_next |->
      out_data.phase == i2cdts_pkg::PH_WRITE || out_data.phase == i2cdts_pkg::PH_READ)
    else $error("need_next outside write or read phase");

  // unused fields read as zero
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_data.word_valid || out_data.fifo_word == 10'd0) &&
      (out_data.rx_valid || (out_data.rx_byte == 8'd0 && out_data.rx_index == 8'd0)))
    else $error("invalid field not zero");

endmodule

bind i2c_dynamic_transfer_sequencer_unit i2cdts_checker u_i2cdts_checker (.*);
